// ===== rtl/skts_pkg.sv =====
// shared constants, types and helpers for the sorted key table search
package skts_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int LINEAR_SPAN = 5;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = 11;
   localparam int CODE_W      = 16;
   localparam int KEY_W       = 2 * CODE_W;
   localparam int POS_W       = 32;
   localparam int REC_W       = KEY_W + POS_W;

   typedef enum logic [0:0] {
      KIND_LOAD   = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } seq_state_type;

   // finished lookup handed from the sequencer to the output register
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] position;
   } result_type;

   function automatic logic [KEY_W-1:0] rec_key(input logic [REC_W-1:0] rec);
      rec_key = rec[REC_W-1:POS_W];
   endfunction

   function automatic logic [POS_W-1:0] rec_pos(input logic [REC_W-1:0] rec);
      rec_pos = rec[POS_W-1:0];
   endfunction

endpackage

// ===== rtl/skts_ram.sv =====
// generic simple dual port ram with registered read
module skts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/skts_seq.sv =====
// lookup sequencer: halving probes then a linear tail over one shared compare
module skts_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [skts_pkg::KEY_W-1:0]  query,
   input  logic [skts_pkg::COUNT_W-1:0] record_count,
   output logic                        idle,
   output logic                        rd_en,
   output logic [skts_pkg::ADDR_W-1:0] rd_addr,
   input  logic [skts_pkg::REC_W-1:0]  rd_data,
   input  logic                        out_free,
   output skts_pkg::result_type        result
);
   import skts_pkg::*;

   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);
   localparam logic [ADDR_W-1:0]  SPAN        = ADDR_W'(LINEAR_SPAN);

   seq_state_type      state_ff, state_in;
   logic               linear_ff, linear_in;
   logic [ADDR_W-1:0]  lo_ff, lo_in;
   logic [ADDR_W-1:0]  hi_ff, hi_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [KEY_W-1:0]   query_ff, query_in;
   logic               found_ff, found_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   logic [COUNT_W-1:0] count_sat;
   logic [ADDR_W-1:0]  first_hi;
   logic [KEY_W-1:0]   probe_key;
   logic [ADDR_W-1:0]  new_lo;
   logic [ADDR_W-1:0]  new_hi;
   logic [ADDR_W-1:0]  span;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // search registers
   always_ff @(posedge clock) begin
      linear_ff <= linear_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      addr_ff   <= addr_in;
      query_ff  <= query_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
   end

   // shared compare and bound update
   always_comb begin
      count_sat = (record_count > DEPTH_COUNT) ? DEPTH_COUNT : record_count;
      first_hi  = ADDR_W'(count_sat - COUNT_W'(1));
      probe_key = rec_key(rd_data);
      new_lo    = lo_ff;
      new_hi    = hi_ff;
      if (probe_key > query_ff) begin
         new_hi = addr_ff;
      end else begin
         new_lo = addr_ff;
      end
      span = new_hi - new_lo;
   end

   // next state and outputs
   always_comb begin
      state_in  = state_ff;
      linear_in = linear_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      addr_in   = addr_ff;
      query_in  = query_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      idle      = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = addr_ff;
      result.valid    = 1'b0;
      result.found    = found_ff;
      result.position = pos_ff;

      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               query_in = query;
               found_in = 1'b0;
               pos_in   = '0;
               lo_in    = '0;
               hi_in    = first_hi;
               if (count_sat == '0) begin
                  state_in = ST_DONE;
               end else if (first_hi > SPAN) begin
                  linear_in = 1'b0;
                  addr_in   = first_hi >> 1;
                  state_in  = ST_READ;
               end else begin
                  linear_in = 1'b1;
                  addr_in   = '0;
                  state_in  = ST_READ;
               end
            end
         end

         // table read at the probe address
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CMP;
         end

         ST_CMP: begin
            if (probe_key == query_ff) begin
               found_in = 1'b1;
               pos_in   = rec_pos(rd_data);
               state_in = ST_DONE;
            end else if (!linear_ff) begin
               // halving step, then either another probe or the tail scan
               lo_in = new_lo;
               hi_in = new_hi;
               if (span > SPAN) begin
                  addr_in = new_lo + (span >> 1);
               end else begin
                  linear_in = 1'b1;
                  addr_in   = new_lo;
               end
               state_in = ST_READ;
            end else if (addr_ff == hi_ff) begin
               state_in = ST_DONE;
            end else begin
               addr_in  = addr_ff + ADDR_W'(1);
               state_in = ST_READ;
            end
         end

         // hand the answer to the output register
         ST_DONE: begin
            result.valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/sorted_key_table_search.sv =====
// sorted key table search: record loads and key lookups over one table memory
//
// Input channel req_*: a transfer with req_kind 0 loads one record
// (area code, cell number, data position) into slot req_record_index and
// gives no response. A transfer with req_kind 1 looks up the key
// (area code, cell number) and gives exactly one response on rsp_*.
// csr_wr_en/csr_wr_data set the record count; write it only while idle.
// A lookup runs halving probes while the bound span exceeds five, then
// scans the remaining slots in order. Each probe is one table memory read
// followed by one key compare, with at most thirteen probes in all; with a
// zero record count the lookup answers not found without any probe.
// req_ready is low while a lookup is in progress.
// The response sits in an output register, so the next request is taken
// while it waits; if rsp_ready stays low, a further lookup holds its answer
// and stays busy until the register frees.
// Reset clears the record count and all handshake state; table contents
// are undefined until loaded.
module sorted_key_table_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [9:0]                    req_record_index,
   input  logic [15:0]                   req_area_code,
   input  logic [15:0]                   req_cell_number,
   input  logic [31:0]                   req_data_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [31:0]                   rsp_found_position,
   input  logic                          csr_wr_en,
   input  logic [skts_pkg::COUNT_W-1:0]  csr_wr_data
);
   import skts_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;

   logic               req_xfer;
   logic               load_we;
   logic               lookup_start;
   logic               seq_idle;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [REC_W-1:0]   rd_data;
   logic               out_free;
   result_type         result;

   // request decode
   assign req_ready    = seq_idle;
   assign req_xfer     = req_valid & req_ready;
   assign load_we      = req_xfer & (req_kind == KIND_LOAD);
   assign lookup_start = req_xfer & (req_kind == KIND_LOOKUP);
   assign out_free     = ~rsp_valid_ff | rsp_ready;

   skts_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (ADDR_W'(req_record_index)),
      .wr_data ({req_area_code, req_cell_number, req_data_position}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   skts_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (lookup_start),
      .query        ({req_area_code, req_cell_number}),
      .record_count (count_ff),
      .idle         (seq_idle),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .out_free     (out_free),
      .result       (result)
   );

   // record count register and response register next values
   always_comb begin
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (result.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = result.found;
         rsp_pos_in   = result.position;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_pos_ff;

endmodule
